### hdl/terminal_key_escape_decoder_defines.svh
// Assertion macros shared by the terminal key decoder RTL.
`ifndef TERMINAL_KEY_ESCAPE_DECODER_DEFINES_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tkd_pkg.sv
// Package: key codes, parser states and shared types of the terminal key decoder.
package tkd_pkg;

  // Dense key codes
  localparam logic [4:0] KC_UP              = 5'd0;
  localparam logic [4:0] KC_DOWN            = 5'd1;
  localparam logic [4:0] KC_RIGHT           = 5'd2;
  localparam logic [4:0] KC_LEFT            = 5'd3;
  localparam logic [4:0] KC_HOME            = 5'd4;
  localparam logic [4:0] KC_END             = 5'd5;
  localparam logic [4:0] KC_DEL             = 5'd6;
  localparam logic [4:0] KC_PGUP            = 5'd7;
  localparam logic [4:0] KC_PGDOWN          = 5'd8;
  localparam logic [4:0] KC_CTL_LT          = 5'd9;
  localparam logic [4:0] KC_CTL_RT          = 5'd10;
  localparam logic [4:0] KC_SHIFT_LEFT      = 5'd11;
  localparam logic [4:0] KC_SHIFT_RIGHT     = 5'd12;
  localparam logic [4:0] KC_F1              = 5'd13;
  localparam logic [4:0] KC_F6              = 5'd18;
  localparam logic [4:0] KC_F9              = 5'd21;
  localparam logic [4:0] KC_F10             = 5'd22;
  localparam logic [4:0] KC_INS             = 5'd23;
  localparam logic [4:0] KC_ALT_NEWLINE     = 5'd24;
  localparam logic [4:0] KC_ESC             = 5'd25;
  localparam logic [4:0] KC_NEWLINE         = 5'd26;
  localparam logic [4:0] KC_TAB             = 5'd27;
  localparam logic [4:0] KC_SHIFT_IN        = 5'd28;
  localparam logic [4:0] KC_RUBOUT          = 5'd29;

  // Control bytes
  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_SI  = 8'd15;
  localparam logic [7:0] CH_DEL = 8'd127;

  // Output queue depth (two slots per byte plus slack)
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0_0000_0000_0001,
    ST_ESC       = 13'b0_0000_0000_0010,
    ST_CSI       = 13'b0_0000_0000_0100,
    ST_SS3       = 13'b0_0000_0000_1000,
    ST_ESC_E     = 13'b0_0000_0001_0000,
    ST_ESC_LET   = 13'b0_0000_0010_0000,
    ST_CSI3      = 13'b0_0000_0100_0000,
    ST_CSI1      = 13'b0_0000_1000_0000,
    ST_CSI2      = 13'b0_0001_0000_0000,
    ST_MOD       = 13'b0_0010_0000_0000,
    ST_MOD_CTRL  = 13'b0_0100_0000_0000,
    ST_MOD_SHIFT = 13'b0_1000_0000_0000,
    ST_TAIL      = 13'b1_0000_0000_0000
  } tkd_state_t;

  typedef struct packed {
    logic       is_key;
    logic [7:0] value;
    logic       last_of_run;
  } tkd_result_t;

  // Decoder verdict for one byte
  typedef struct packed {
    logic [1:0]  count;
    tkd_result_t r0;
    tkd_result_t r1;
    tkd_state_t  state;
    logic [4:0]  pend;
  } tkd_dec_t;

endpackage

### hdl/tkd_if.sv
// Valid/ready stream interfaces for the decoder's byte input and key output.
interface tkd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tkd_out_if;
  logic       valid;
  logic       ready;
  logic       is_key;
  logic [7:0] value;
  logic       last_of_run;

  modport source (output valid, output is_key, output value, output last_of_run, input ready);
  modport sink   (input valid, input is_key, input value, input last_of_run, output ready);
endinterface

### hdl/tkd_decode.sv
// Combinational escape-sequence parser: one byte against the current state.
module tkd_decode
  import tkd_pkg::*;
(
  input  tkd_state_t st_i,
  input  logic [4:0] pend_i,
  input  logic [7:0] byte_i,
  output tkd_dec_t   dec_o
);

  localparam logic [7:0] CH_LBRK  = 8'h5B; // '['
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  function automatic tkd_result_t key_res(input logic [4:0] k, input logic last);
    tkd_result_t r;
    r.is_key      = 1'b1;
    r.value       = {3'b000, k};
    r.last_of_run = last;
    return r;
  endfunction

  // Result of a non-ESC byte seen from idle
  function automatic tkd_result_t idle_res(input logic [7:0] b);
    tkd_result_t r;
    r = '{is_key: 1'b0, value: b, last_of_run: 1'b1};
    if (b == CH_LF)       r = key_res(KC_NEWLINE, 1'b1);
    else if (b == CH_TAB) r = key_res(KC_TAB, 1'b1);
    else if (b == CH_SI)  r = key_res(KC_SHIFT_IN, 1'b1);
    else if (b == CH_DEL) r = key_res(KC_RUBOUT, 1'b1);
    return r;
  endfunction

  localparam tkd_result_t RAW_ESC = '{is_key: 1'b0, value: CH_ESC, last_of_run: 1'b1};

  logic [7:0] off_1;
  logic [7:0] off_7;
  logic [7:0] off_p;

  assign off_1 = byte_i - CH_1;
  assign off_7 = byte_i - CH_7;
  assign off_p = byte_i - CH_P;

  always_comb begin
    dec_o       = '0;
    dec_o.state = ST_IDLE;
    dec_o.pend  = pend_i;
    case (st_i)
      ST_ESC: begin
        if (byte_i == CH_LBRK) begin
          dec_o.state = ST_CSI;
        end else if (byte_i == CH_O) begin
          dec_o.state = ST_SS3;
        end else if (byte_i == CH_E) begin
          dec_o.state = ST_ESC_E;
        end else if (byte_i >= CH_A && byte_i <= CH_Z) begin
          dec_o.state = ST_ESC_LET;
        end else if (byte_i == CH_ESC) begin
          dec_o.count = 2'd1;
          dec_o.r0    = key_res(KC_ESC, 1'b1);
        end else begin
          // lone ESC, then the byte is parsed again from idle
          dec_o.count = 2'd2;
          dec_o.r0    = key_res(KC_ESC, 1'b0);
          dec_o.r1    = idle_res(byte_i);
        end
      end
      ST_ESC_E: begin
        dec_o.count = 2'd1;
        dec_o.r0    = (byte_i == CH_LF) ? key_res(KC_ALT_NEWLINE, 1'b1) : RAW_ESC;
      end
      ST_ESC_LET: begin
        dec_o.count = 2'd1;
        dec_o.r0    = RAW_ESC;
      end
      ST_SS3: begin
        dec_o.count = 2'd1;
        dec_o.r0    = (byte_i >= CH_P && byte_i <= CH_S) ?
                      key_res(KC_F1 + off_p[4:0], 1'b1) : RAW_ESC;
      end
      ST_CSI: begin
        if (byte_i == CH_3) begin
          dec_o.state = ST_CSI3;
        end else if (byte_i == CH_5) begin
          dec_o.state = ST_TAIL;
          dec_o.pend  = KC_PGUP;
        end else if (byte_i == CH_6) begin
          dec_o.state = ST_TAIL;
          dec_o.pend  = KC_PGDOWN;
        end else if (byte_i == CH_1) begin
          dec_o.state = ST_CSI1;
        end else if (byte_i == CH_2) begin
          dec_o.state = ST_CSI2;
        end else begin
          dec_o.count = 2'd1;
          if (byte_i == CH_A)      dec_o.r0 = key_res(KC_UP, 1'b1);
          else if (byte_i == CH_B) dec_o.r0 = key_res(KC_DOWN, 1'b1);
          else if (byte_i == CH_C) dec_o.r0 = key_res(KC_RIGHT, 1'b1);
          else if (byte_i == CH_D) dec_o.r0 = key_res(KC_LEFT, 1'b1);
          else if (byte_i == CH_H) dec_o.r0 = key_res(KC_HOME, 1'b1);
          else if (byte_i == CH_F) dec_o.r0 = key_res(KC_END, 1'b1);
          else                     dec_o.r0 = RAW_ESC;
        end
      end
      ST_CSI3: begin
        dec_o.count = 2'd1;
        dec_o.r0    = (byte_i == CH_TILDE) ? key_res(KC_DEL, 1'b1) : RAW_ESC;
      end
      ST_CSI1: begin
        if (byte_i == CH_SEMI) begin
          dec_o.state = ST_MOD;
        end else if (byte_i >= CH_1 && byte_i <= CH_5) begin
          dec_o.state = ST_TAIL;
          dec_o.pend  = KC_F1 + off_1[4:0];
        end else if (byte_i >= CH_7 && byte_i <= CH_9) begin
          dec_o.state = ST_TAIL;
          dec_o.pend  = KC_F6 + off_7[4:0];
        end else begin
          dec_o.count = 2'd1;
          dec_o.r0    = RAW_ESC;
        end
      end
      ST_CSI2: begin
        if (byte_i == CH_0) begin
          dec_o.state = ST_TAIL;
          dec_o.pend  = KC_F9;
        end else if (byte_i == CH_1) begin
          dec_o.state = ST_TAIL;
          dec_o.pend  = KC_F10;
        end else begin
          dec_o.count = 2'd1;
          dec_o.r0    = (byte_i == CH_TILDE) ? key_res(KC_INS, 1'b1) : RAW_ESC;
        end
      end
      ST_MOD: begin
        if (byte_i == CH_5) begin
          dec_o.state = ST_MOD_CTRL;
        end else if (byte_i == CH_2) begin
          dec_o.state = ST_MOD_SHIFT;
        end else begin
          dec_o.count = 2'd1;
          dec_o.r0    = RAW_ESC;
        end
      end
      ST_MOD_CTRL: begin
        dec_o.count = 2'd1;
        if (byte_i == CH_D)      dec_o.r0 = key_res(KC_CTL_LT, 1'b1);
        else if (byte_i == CH_C) dec_o.r0 = key_res(KC_CTL_RT, 1'b1);
        else                     dec_o.r0 = RAW_ESC;
      end
      ST_MOD_SHIFT: begin
        dec_o.count = 2'd1;
        if (byte_i == CH_D)      dec_o.r0 = key_res(KC_SHIFT_LEFT, 1'b1);
        else if (byte_i == CH_C) dec_o.r0 = key_res(KC_SHIFT_RIGHT, 1'b1);
        else                     dec_o.r0 = RAW_ESC;
      end
      ST_TAIL: begin
        // trailing '~' is not checked
        dec_o.count = 2'd1;
        dec_o.r0    = key_res(pend_i, 1'b1);
      end
      default: begin
        if (byte_i == CH_ESC) begin
          dec_o.state = ST_ESC;
        end else begin
          dec_o.count = 2'd1;
          dec_o.r0    = idle_res(byte_i);
        end
      end
    endcase
  end

endmodule

### hdl/terminal_key_escape_decoder.sv
// Top level: VT100/ANSI terminal key escape decoder with input register and result queue.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-------------------------------------
//   in_ch   | in  | valid/ready   | in_byte[7:0]
//   out_ch  | out | valid/ready   | is_key, value[7:0], last_of_run
//
// One byte per cycle enters the input register while the queue has room; from there it is parsed
// against the state register and its 0, 1 or 2 results land in a 4-entry queue.
// A byte leaves the input register only when the queue has room for two results;
// sustained rate is one byte per cycle, bounded by one result per output cycle.
// rst_n (synchronous, active low) returns the parser to idle and empties the queue.
// A stalled out_ch fills the queue and then holds off in_ch through in_ch.ready.
`include "terminal_key_escape_decoder_defines.svh"

module terminal_key_escape_decoder
  import tkd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tkd_in_if.sink      in_ch,
  tkd_out_if.source   out_ch
);

  // Input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;

  // Parser state
  tkd_state_t state_r;
  logic [4:0] pend_r;

  // Result queue
  tkd_result_t      q_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  tkd_dec_t dec;
  logic     in_acc;
  logic     dec_fire;
  logic     pop;
  logic [QAW-1:0] wr_ptr_p1;

  tkd_decode u_decode (
    .st_i   (state_r),
    .pend_i (pend_r),
    .byte_i (s1_byte_r),
    .dec_o  (dec)
  );

  // Parse only when two queue slots are free, so a two-result byte never stalls mid-way
  assign dec_fire     = s1_vld_r && (cnt_r <= (QAW+1)'(QDEPTH - 2));
  assign in_ch.ready  = !s1_vld_r || dec_fire;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.is_key      = q_r[rd_ptr_r].is_key;
  assign out_ch.value       = q_r[rd_ptr_r].value;
  assign out_ch.last_of_run = q_r[rd_ptr_r].last_of_run;
  assign pop                = out_ch.valid && out_ch.ready;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (dec_fire) begin
      wr_ptr_nxt = wr_ptr_r + QAW'(dec.count);
      cnt_nxt    = cnt_r + (QAW+1)'(dec.count);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
      cnt_nxt    = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      state_r  <= ST_IDLE;
      pend_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (dec_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (dec_fire) begin
        state_r <= dec.state;
        pend_r  <= dec.pend;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.in_byte;
    end
    if (dec_fire && dec.count != 2'd0) begin
      q_r[wr_ptr_r] <= dec.r0;
    end
    if (dec_fire && dec.count == 2'd2) begin
      q_r[wr_ptr_p1] <= dec.r1;
    end
  end

  // Assertions
  `TKD_ASSERT_NXT(a_in_lands, in_acc, s1_vld_r, "accepted byte not held in input register")
  `TKD_ASSERT_NOW(a_fire_room, dec_fire, cnt_r <= (QAW+1)'(QDEPTH - 2), "parse without queue room")
  `TKD_ASSERT_NOW(a_run_whole, out_ch.valid && !out_ch.last_of_run, cnt_r >= (QAW+1)'(2), "run split across parses")
  `TKD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= (QAW+1)'(QDEPTH), "result queue overflow")

endmodule

### verif/key_stream_checker.sv
// Checker for the terminal key decoder: predicts the results of each accepted byte and compares.
module key_stream_checker
  import tkd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_is_key,
  input  logic [7:0] out_value,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         outstanding,
  output int         results_checked,
  output int         keys_checked
);

  tkd_state_t  parse_st;
  logic [4:0]  held_key;
  tkd_result_t expected_q[$];
  tkd_result_t want;
  int          run_len;
  int          mismatches;
  int          n_results;
  int          n_keys;

  initial begin
    fail_count      = 0;
    outstanding     = 0;
    results_checked = 0;
    keys_checked    = 0;
    mismatches      = 0;
    n_results       = 0;
    n_keys          = 0;
    parse_st        = ST_IDLE;
    held_key        = '0;
  end

  // at most two results per byte; the newest one carries last_of_run
  function automatic void note_result(input logic k, input logic [7:0] v);
    tkd_result_t r;
    if (run_len >= 2) return;
    if (run_len > 0) expected_q[expected_q.size() - 1].last_of_run = 1'b0;
    r.is_key      = k;
    r.value       = v;
    r.last_of_run = 1'b1;
    expected_q.push_back(r);
    run_len++;
  endfunction

  function automatic void finish_key(input logic [4:0] k);
    note_result(1'b1, 8'(k));
    parse_st = ST_IDLE;
  endfunction

  // broken sequence: raw ESC out, back to idle
  function automatic void abandon_seq();
    note_result(1'b0, CH_ESC);
    parse_st = ST_IDLE;
  endfunction

  function automatic void idle_decode(input logic [7:0] b);
    parse_st = ST_IDLE;
    if (b == CH_ESC)      parse_st = ST_ESC;
    else if (b == CH_LF)  note_result(1'b1, 8'(KC_NEWLINE));
    else if (b == CH_TAB) note_result(1'b1, 8'(KC_TAB));
    else if (b == CH_SI)  note_result(1'b1, 8'(KC_SHIFT_IN));
    else if (b == CH_DEL) note_result(1'b1, 8'(KC_RUBOUT));
    else                  note_result(1'b0, b);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    run_len = 0;
    case (parse_st)
      ST_ESC: begin
        if (b == "[")                  parse_st = ST_CSI;
        else if (b == "O")             parse_st = ST_SS3;
        else if (b == "E")             parse_st = ST_ESC_E;
        else if (b >= "A" && b <= "Z") parse_st = ST_ESC_LET;
        else if (b == CH_ESC)          finish_key(KC_ESC);
        else begin
          // lone ESC, then the byte is decoded from idle
          note_result(1'b1, 8'(KC_ESC));
          idle_decode(b);
        end
      end
      ST_ESC_E: begin
        if (b == CH_LF) finish_key(KC_ALT_NEWLINE);
        else abandon_seq();
      end
      ST_ESC_LET: abandon_seq();
      ST_SS3: begin
        if (b >= "P" && b <= "S") finish_key(KC_F1 + 5'(b - "P"));
        else abandon_seq();
      end
      ST_CSI: begin
        if (b == "A")      finish_key(KC_UP);
        else if (b == "B") finish_key(KC_DOWN);
        else if (b == "C") finish_key(KC_RIGHT);
        else if (b == "D") finish_key(KC_LEFT);
        else if (b == "H") finish_key(KC_HOME);
        else if (b == "F") finish_key(KC_END);
        else if (b == "3") parse_st = ST_CSI3;
        else if (b == "5") begin
          held_key = KC_PGUP;
          parse_st = ST_TAIL;
        end else if (b == "6") begin
          held_key = KC_PGDOWN;
          parse_st = ST_TAIL;
        end else if (b == "1") parse_st = ST_CSI1;
        else if (b == "2") parse_st = ST_CSI2;
        else abandon_seq();
      end
      ST_CSI3: begin
        if (b == "~") finish_key(KC_DEL);
        else abandon_seq();
      end
      ST_CSI1: begin
        if (b == ";") parse_st = ST_MOD;
        else if (b >= "1" && b <= "5") begin
          held_key = KC_F1 + 5'(b - "1");
          parse_st = ST_TAIL;
        end else if (b >= "7" && b <= "9") begin
          held_key = KC_F6 + 5'(b - "7");
          parse_st = ST_TAIL;
        end else abandon_seq();
      end
      ST_CSI2: begin
        if (b == "0") begin
          held_key = KC_F9;
          parse_st = ST_TAIL;
        end else if (b == "1") begin
          held_key = KC_F10;
          parse_st = ST_TAIL;
        end else if (b == "~") finish_key(KC_INS);
        else abandon_seq();
      end
      ST_MOD: begin
        if (b == "5")      parse_st = ST_MOD_CTRL;
        else if (b == "2") parse_st = ST_MOD_SHIFT;
        else abandon_seq();
      end
      ST_MOD_CTRL: begin
        if (b == "D")      finish_key(KC_CTL_LT);
        else if (b == "C") finish_key(KC_CTL_RT);
        else abandon_seq();
      end
      ST_MOD_SHIFT: begin
        if (b == "D")      finish_key(KC_SHIFT_LEFT);
        else if (b == "C") finish_key(KC_SHIFT_RIGHT);
        else abandon_seq();
      end
      // trailing byte is taken without a look
      ST_TAIL: finish_key(held_key);
      default: idle_decode(b);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_st = ST_IDLE;
      held_key = '0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: is_key=%0d value=0x%02h last_of_run=%0d",
                 out_is_key, out_value, out_last_of_run);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          n_results++;
          if (want.is_key) n_keys++;
          if (out_is_key !== want.is_key) begin
            $error("is_key: expected %0d, actual %0d", want.is_key, out_is_key);
            mismatches++;
          end
          if (out_value !== want.value) begin
            $error("value: expected 0x%02h, actual 0x%02h", want.value, out_value);
            mismatches++;
          end
          if (out_last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                   out_last_of_run);
            mismatches++;
          end
        end
      end
    end
    fail_count      <= mismatches;
    outstanding     <= expected_q.size();
    results_checked <= n_results;
    keys_checked    <= n_keys;
  end

endmodule

### verif/tb_terminal_key_escape_decoder.sv
// Testbench top for the terminal key decoder: byte stimulus, output back-pressure and verdict.
module tb_terminal_key_escape_decoder
  import tkd_pkg::*;
();

  // Output hold length during the back-pressure phase
  localparam int CHOKE_CYCLES = 300;
  // Settle time after the last expected result
  localparam int TAIL_CYCLES  = 8;
  // Bound on each wait for outstanding results
  localparam int DRAIN_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst_n;

  // Shared phase flags, driven by the stimulus process only
  logic steady    = 1'b0;  // both sides run without gaps
  logic choke_req = 1'b0;  // receiver should take its long hold
  bit   rush      = 1'b0;  // sender runs without gaps

  int bytes_sent  = 0;
  int drain_fails = 0;
  int long_holds  = 0;

  int fail_count;
  int outstanding;
  int results_checked;
  int keys_checked;

  logic [7:0] seq_q[$];

  // Opening bytes: field extremes, the four control keys, ESC with an odd byte,
  // ESC ESC, ESC E newline, ESC letter with a non-newline byte, a PgUp tail,
  // and the second F-key digit right after ESC [ 1.
  logic [7:0] opening[$] = '{8'h00, 8'hFF, CH_LF, CH_TAB, CH_SI, CH_DEL,
                             CH_ESC, "a", CH_ESC, CH_ESC, CH_ESC, "E", CH_LF,
                             CH_ESC, "Q", "z", CH_ESC, "[", "5", "~",
                             CH_ESC, "[", "1", "7", "~"};

  tkd_in_if  in_ch();
  tkd_out_if out_ch();

  terminal_key_escape_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_stream_checker key_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_byte         (in_ch.in_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_is_key      (out_ch.is_key),
    .out_value       (out_ch.value),
    .out_last_of_run (out_ch.last_of_run),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .keys_checked    (keys_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Gap lengths: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Terminator after PgUp/PgDn/F-keys: usually '~', sometimes junk (never checked)
  function automatic logic [7:0] tail_byte();
    return ($urandom_range(0, 3) == 0) ? any_byte() : 8'("~");
  endfunction

  // Offer one item and hold it until accepted, then maybe idle a while.
  // valid is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    gap = (rush || steady) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Build one key sequence with random content; about one in five multi-byte sequences
  // is broken by swapping a later byte for junk and dropping the rest.
  task automatic compose_sequence();
    int cut;
    seq_q.delete();
    case ($urandom_range(0, 15))
      0, 1: seq_q.push_back(any_byte());
      2: begin
        case ($urandom_range(0, 3))
          0: seq_q.push_back(CH_LF);
          1: seq_q.push_back(CH_TAB);
          2: seq_q.push_back(CH_SI);
          default: seq_q.push_back(CH_DEL);
        endcase
      end
      3: seq_q = '{CH_ESC, "[", pick_char("ABCDHF")};
      4: seq_q = '{CH_ESC, "[", "3", "~"};
      5: seq_q = '{CH_ESC, "[", pick_char("56"), tail_byte()};
      6: seq_q = '{CH_ESC, "[", "1", pick_char("12345789"), tail_byte()};
      7: seq_q = '{CH_ESC, "[", "2", pick_char("01"), tail_byte()};
      8: seq_q = '{CH_ESC, "[", "2", "~"};
      9: seq_q = '{CH_ESC, "[", "1", ";", pick_char("52"), pick_char("CD")};
      10: seq_q = '{CH_ESC, "O", pick_char("PQRS")};
      11: seq_q = '{CH_ESC, "E", CH_LF};
      12: seq_q = '{CH_ESC, 8'($urandom_range(65, 90)), any_byte()};
      13: seq_q = '{CH_ESC, CH_ESC};
      default: seq_q = '{CH_ESC, any_byte()};
    endcase
    if (seq_q.size() > 1 && $urandom_range(0, 99) < 20) begin
      cut = $urandom_range(1, seq_q.size() - 1);
      seq_q[cut] = any_byte();
      while (seq_q.size() > cut + 1) void'(seq_q.pop_back());
    end
  endtask

  task automatic stream_sequences(input int n);
    int target;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      compose_sequence();
      foreach (seq_q[i]) send_byte(seq_q[i]);
    end
  endtask

  // Stop offering, wait for every predicted result, then let the pipe settle
  task automatic wait_drained();
    int spin;
    in_ch.valid <= 1'b0;
    spin = 0;
    do begin
      @(posedge clk);
      spin++;
    end while (outstanding != 0 && spin < DRAIN_LIMIT);
    if (outstanding != 0) begin
      $error("%0d expected results never arrived", outstanding);
      drain_fails++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Receiver: random ready bursts and gaps; one long hold when asked,
  // counted here while the sender keeps pushing.
  initial begin
    int burst;
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (choke_req) begin
        out_ch.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
        long_holds++;
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (choke_req);
      end else begin
        burst = $urandom_range(1, 8);
        gap   = steady ? 0 : pick_gap();
        out_ch.ready <= 1'b1;
        repeat (burst) @(posedge clk);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    rst_n         <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) send_byte(opening[i]);
    wait_drained();

    stream_sequences(600);
    wait_drained();

    // Back-pressure: output held off while input is offered without gaps,
    // so the result queue fills and in_ch.ready drops
    choke_req <= 1'b1;
    rush = 1'b1;
    stream_sequences(120);
    rush = 1'b0;
    choke_req <= 1'b0;
    wait_drained();

    // Full-rate stretch, no idling on either side
    steady <= 1'b1;
    stream_sequences(200);
    steady <= 1'b0;
    wait_drained();

    stream_sequences(680);
    wait_drained();

    $display("Run covered %0d input bytes and %0d checked results, %0d of them key codes.",
             bytes_sent, results_checked, keys_checked);
    $display("It included %0d long output hold(s) of %0d cycles and drained pauses between phases.",
             long_holds, CHOKE_CYCLES);
    if (fail_count == 0 && drain_fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/tkd_pkg.sv
hdl/tkd_if.sv
hdl/tkd_decode.sv
hdl/terminal_key_escape_decoder.sv
verif/key_stream_checker.sv
verif/tb_terminal_key_escape_decoder.sv
